>>> design/fwsplat_pkg.sv
// Shared types, codes and constants of the forward flow warp splat block.
`default_nettype none

package fwsplat_pkg;

	// Default build sizes
	localparam int MAX_WIDTH_DEF      = 256;
	localparam int MAX_HEIGHT_DEF     = 256;
	localparam int FLOW_FRAC_BITS_DEF = 4;

	// Size registers: width, reset value, fill value of a fresh frame
	localparam int         SIZE_W     = 9;
	localparam logic [8:0] SIZE_RESET = 9'd256;
	localparam logic [7:0] CLEAR_PIX  = 8'd127;

	// Request type codes
	localparam logic REQ_SPLAT = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Configuration register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Request transaction payload
	typedef struct packed {
		logic               req_type;
		logic               frame_start;
		logic [7:0]         pixel_value;
		logic signed [15:0] flow_x;
		logic signed [15:0] flow_y;
		logic [7:0]         read_col;
		logic [7:0]         read_row;
	} req_t;

	// Response transaction payload
	typedef struct packed {
		logic [7:0] aligned_value;
		logic       out_of_range;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic read_en;     // look up the read position
		logic splat_en;    // write a splat and step the raster position
		logic splat_hold;  // splat source is the held frame-start pixel
		logic start_frame; // hold the splat, restart raster, arm the sweep
		logic clear_en;    // write one sweep entry
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic room;       // a request may be taken this cycle
		logic clear_last; // sweep is on its final entry
	} sts_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_CLEAR,
		ST_APPLY
	} state_t;

endpackage

`default_nettype wire

>>> design/fwsplat_ctrl.sv
// Controller state machine: request handshake, frame clear sequencing.
`default_nettype none

module fwsplat_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire                 req_type,
	input  wire                 req_frame_start,
	input  fwsplat_pkg::sts_t   sts,
	output fwsplat_pkg::cmd_t   cmd
);

	fwsplat_pkg::state_t state_q, state_d;
	logic                accept;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwsplat_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		accept    = 1'b0;
		unique case (state_q)
			fwsplat_pkg::ST_RUN: begin
				req_stall = !sts.room;
				accept    = req_valid && sts.room;
				if (accept) begin
					if (req_type == fwsplat_pkg::REQ_READ) begin
						cmd.read_en = 1'b1;
					end else if (req_frame_start) begin
						cmd.start_frame = 1'b1;
						state_d         = fwsplat_pkg::ST_CLEAR;
					end else begin
						cmd.splat_en = 1'b1;
					end
				end
			end
			fwsplat_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = fwsplat_pkg::ST_APPLY;
				end
			end
			fwsplat_pkg::ST_APPLY: begin
				cmd.splat_en   = 1'b1;
				cmd.splat_hold = 1'b1;
				state_d        = fwsplat_pkg::ST_RUN;
			end
			default: begin
				state_d = fwsplat_pkg::ST_RUN;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/fwsplat_dp.sv
// Datapath: size registers, raster counters, target arithmetic, frame buffer, response path.
`default_nettype none

module fwsplat_dp #(
	parameter int MAX_WIDTH      = fwsplat_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT     = fwsplat_pkg::MAX_HEIGHT_DEF,
	parameter int FLOW_FRAC_BITS = fwsplat_pkg::FLOW_FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fwsplat_pkg::req_t   req,
	input  fwsplat_pkg::cmd_t   cmd,
	output fwsplat_pkg::sts_t   sts,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire                 cfg_index,
	input  wire [8:0]           cfg_data,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output fwsplat_pkg::rsp_t   rsp
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MW    = (CW > RW) ? CW : RW;
	localparam int EW    = (MW + 1 > fwsplat_pkg::SIZE_W) ? MW + 1 : fwsplat_pkg::SIZE_W;
	localparam int TW    = ((MW > 16) ? MW : 16) + 2;
	localparam int AW    = CW + RW;
	localparam int DEPTH = 2 ** AW;

	// Size registers and effective sizes
	logic [8:0]    width_q, height_q;
	logic [EW-1:0] width_ext, height_ext, eff_w, eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fwsplat_pkg::SIZE_RESET;
			height_q <= fwsplat_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fwsplat_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				fwsplat_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext  = EW'(width_q);
		height_ext = EW'(height_q);
		if (width_ext == '0) begin
			eff_w = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
		if (height_ext == '0) begin
			eff_h = EW'(1);
		end else if (height_ext > EW'(MAX_HEIGHT)) begin
			eff_h = EW'(MAX_HEIGHT);
		end else begin
			eff_h = height_ext;
		end
	end

	// Held frame-start splat and sweep counter
	logic [7:0]         hold_pix_q;
	logic signed [15:0] hold_fx_q, hold_fy_q;
	logic [AW-1:0]      sweep_q;

	always_ff @(posedge clk) begin
		if (cmd.start_frame) begin
			hold_pix_q <= req.pixel_value;
			hold_fx_q  <= req.flow_x;
			hold_fy_q  <= req.flow_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.start_frame) begin
			sweep_q <= '0;
		end else if (cmd.clear_en) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	assign sts.clear_last = &sweep_q;

	// Raster position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [EW-1:0] col_nxt, row_nxt;

	assign col_nxt = EW'(col_q) + EW'(1);
	assign row_nxt = EW'(row_q) + EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.start_frame) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.splat_en) begin
			if (col_nxt >= eff_w) begin
				col_q <= '0;
				row_q <= (row_nxt >= eff_h) ? '0 : row_nxt[RW-1:0];
			end else begin
				col_q <= col_nxt[CW-1:0];
			end
		end
	end

	// Splat target: raster position plus floored flow
	logic [7:0]         src_pix;
	logic signed [15:0] src_fx, src_fy, fl_x, fl_y;
	logic [TW-1:0]      tx, ty;
	logic               tgt_in;

	always_comb begin
		src_pix = cmd.splat_hold ? hold_pix_q : req.pixel_value;
		src_fx  = cmd.splat_hold ? hold_fx_q  : req.flow_x;
		src_fy  = cmd.splat_hold ? hold_fy_q  : req.flow_y;
		fl_x    = src_fx >>> FLOW_FRAC_BITS;
		fl_y    = src_fy >>> FLOW_FRAC_BITS;
		tx      = TW'(col_q) + TW'(fl_x);
		ty      = TW'(row_q) + TW'(fl_y);
		tgt_in  = !tx[TW-1] && !ty[TW-1] && (tx < TW'(eff_w)) && (ty < TW'(eff_h));
	end

	// Read position check
	logic [EW-1:0] rc, rr;
	logic          rd_in;

	assign rc    = EW'(req.read_col);
	assign rr    = EW'(req.read_row);
	assign rd_in = (rc < eff_w) && (rr < eff_h);

	// Frame buffer: one write port, one registered read port
	logic [7:0]    mem [DEPTH];
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data;
	logic [7:0]    rdata_s1;
	logic          oor_s1;

	always_comb begin
		if (cmd.clear_en) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = fwsplat_pkg::CLEAR_PIX;
		end else begin
			wr_en   = cmd.splat_en && tgt_in;
			wr_addr = {ty[RW-1:0], tx[CW-1:0]};
			wr_data = src_pix;
		end
	end

	assign rd_addr = {rr[RW-1:0], rc[CW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.read_en) begin
			rdata_s1 <= mem[rd_addr];
			oor_s1   <= !rd_in;
		end
	end

	// Response path: looked-up entry, then output register
	logic              pend_s1, out_free, move;
	logic              rsp_valid_q;
	fwsplat_pkg::rsp_t rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign move     = pend_s1 && out_free;
	assign sts.room = !pend_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.read_en) begin
				pend_s1 <= 1'b1;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp_q.aligned_value <= oor_s1 ? 8'd0 : rdata_s1;
			rsp_q.out_of_range  <= oor_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> design/forward_flow_warp_splat.sv
// Top level of the forward flow warp splat block: controller plus datapath.
// The response to a read transaction passes the lookup register and then the output register.
// Throughput: one transaction per cycle while responses drain and no frame start is in progress.
// A frame-start splat sweeps the whole buffer (2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT))
// entries, 65536 by default, one entry per cycle on the single write port), then writes the held splat.
// Reset: raster position 0, sizes 256; buffer contents undefined until the first frame start.
`default_nettype none

module forward_flow_warp_splat #(
	parameter int MAX_WIDTH      = fwsplat_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT     = fwsplat_pkg::MAX_HEIGHT_DEF,
	parameter int FLOW_FRAC_BITS = fwsplat_pkg::FLOW_FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  fwsplat_pkg::req_t   req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output fwsplat_pkg::rsp_t   rsp,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_index,
	input  wire [8:0]           cfg_data
);

	fwsplat_pkg::cmd_t cmd;
	fwsplat_pkg::sts_t sts;

	// Size registers take a write in any cycle
	assign cfg_ready = 1'b1;

	fwsplat_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req.req_type),
		.req_frame_start (req.frame_start),
		.sts             (sts),
		.cmd             (cmd)
	);

	fwsplat_dp #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.FLOW_FRAC_BITS (FLOW_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
